// ===== hdl/shs_pkg.sv =====
// shared types, constants and sha-256 functions for the stream hasher
// no dependencies; imported by shs_sched, shs_round and the top level
`default_nettype none

package shs_pkg;

  localparam int WordW      = 32;
  localparam int BlockBytes = 64;
  localparam int BlockBits  = BlockBytes * 8;
  localparam int LenW       = 61;

  typedef logic [WordW-1:0] word_t;
  typedef logic [7:0][WordW-1:0] wvec_t;   // index 0 is word a / digest word 0

  localparam logic [7:0] PadMark = 8'h80;

  localparam wvec_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // block buffer / schedule window control
  typedef struct packed {
    logic       load;      // shift one message byte in
    logic       expand;    // consume w[t], append w[t+16]
    logic [7:0] byte_val;
  } shs_buf_ctl_t;

  // round unit control
  typedef struct packed {
    logic init;            // load working variables from chain words
    logic step;            // run one round
  } shs_rnd_ctl_t;

  function automatic word_t rotr(input word_t x, input int s);
    rotr = (x >> s) | (x << (WordW - s));
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/shs_sched.sv =====
// block buffer and message schedule window: 64-byte shift line
// depends on shs_pkg
`default_nettype none

module shs_sched
  import shs_pkg::*;
(
  input  wire logic         clk,
  input  wire shs_buf_ctl_t ctl,
  output word_t             w_cur
);

  logic [BlockBits-1:0] win_r;
  logic [BlockBits-1:0] win_nxt;
  word_t                w_new;

  // word i of the window, word 0 in the top bits
  function automatic word_t win_word(input logic [BlockBits-1:0] v, input int i);
    win_word = v[BlockBits-1-WordW*i -: WordW];
  endfunction

  assign w_new = win_word(win_r, 0) + ssig0(win_word(win_r, 1))
               + win_word(win_r, 9) + ssig1(win_word(win_r, 14));

  assign w_cur = win_word(win_r, 0);

  always_comb begin
    win_nxt = win_r;
    if (ctl.load) begin
      win_nxt = {win_r[BlockBits-9:0], ctl.byte_val};
    end else if (ctl.expand) begin
      win_nxt = {win_r[BlockBits-WordW-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/shs_round.sv =====
// sha-256 round unit: working variables a..h and one round per step
// depends on shs_pkg
`default_nettype none

module shs_round
  import shs_pkg::*;
(
  input  wire logic         clk,
  input  wire shs_rnd_ctl_t ctl,
  input  wire wvec_t        chain,
  input  wire word_t        w_in,
  input  wire word_t        k_in,
  output wvec_t             vars
);

  wvec_t v_r;
  wvec_t v_nxt;
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + bsig1(v_r[4]) + ch + k_in + w_in;
  assign t2  = bsig0(v_r[0]) + maj;

  always_comb begin
    v_nxt = v_r;
    if (ctl.init) begin
      v_nxt = chain;
    end else if (ctl.step) begin
      v_nxt = {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + t2};
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign vars = v_r;

endmodule

`default_nettype wire

// ===== hdl/sha256_stream_hasher.sv =====
// top level of the byte-stream sha-256 hasher: handshake, sequencer, chain words
// depends on shs_pkg, shs_sched and shs_round
`default_nettype none

// SHA-256 over a byte stream. Each input transfer carries one message byte in
// in_tdata, a has-byte flag in in_tuser and an end-of-message flag in in_tlast;
// a transfer with in_tuser low and in_tlast high closes the message as it stands
// (so the empty message can be hashed), one with both low does nothing. The
// 64th byte of a block starts a compression that runs the single shared round
// unit through the 64 rounds and then folds the result into the chain words;
// in_tready stays low until the fold is done, so no byte is taken while a block
// is compressed. At end of message the block feeds the padding (0x80, zeros,
// 64-bit big-endian bit length) through the same byte path, one byte per cycle
// between compressions, of which it needs one or two. The digest then leaves as
// eight 32-bit transfers, word 0 (most significant) first; out_tuser is the word
// index and out_tlast marks word 7. The block takes no input while it pads,
// compresses or sends the digest, and returns to its reset state afterwards.
// The message length wraps modulo 2^61 bytes.

module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  wire logic        in_tuser,   // [0] has_byte
  input  wire logic        in_tlast,   // end_of_message
  // digest stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast   // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [5:0]        fill_r, fill_nxt;     // bytes in the current block
  logic [LenW-1:0]   len_r, len_nxt;       // message length in bytes
  wvec_t             chain_r, chain_nxt;
  logic [5:0]        rnd_r, rnd_nxt;
  logic              pad_r, pad_nxt;       // end of message seen, padding under way
  logic              mark_r, mark_nxt;     // 0x80 already placed
  logic              lenph_r, lenph_nxt;   // this block takes the length field
  logic              fin_r, fin_nxt;       // compressing the last padded block
  logic [2:0]        oidx_r, oidx_nxt;

  shs_buf_ctl_t      buf_ctl;
  shs_rnd_ctl_t      rnd_ctl;
  word_t             w_cur;
  wvec_t             vars;

  logic              shift_en;
  logic [7:0]        shift_val;
  logic [7:0]        pad_byte;
  logic [63:0]       bit_len;
  logic [63:0]       bit_len_sh;

  // length field bytes, most significant first, picked by block position
  assign bit_len    = {len_r, 3'b000};
  assign bit_len_sh = bit_len << {fill_r[2:0], 3'b000};

  shs_sched u_sched (
    .clk   (clk),
    .ctl   (buf_ctl),
    .w_cur (w_cur)
  );

  shs_round u_round (
    .clk   (clk),
    .ctl   (rnd_ctl),
    .chain (chain_r),
    .w_in  (w_cur),
    .k_in  (round_k(rnd_r)),
    .vars  (vars)
  );

  // padding byte generator
  always_comb begin
    pad_byte  = 8'h00;
    mark_nxt  = mark_r;
    lenph_nxt = lenph_r;
    fin_nxt   = fin_r;
    if (state_r == ST_PAD) begin
      if (!mark_r) begin
        pad_byte = PadMark;
        mark_nxt = 1'b1;
        // length fits in this block if the mark lands below the length field;
        // a mark in the last slot wraps straight into a fresh block
        lenph_nxt = (fill_r < 6'd56) || (fill_r == 6'd63);
      end else if (lenph_r && (fill_r >= 6'd56)) begin
        pad_byte = bit_len_sh[63:56];
        if (fill_r == 6'd63) begin
          fin_nxt = 1'b1;
        end
      end else if (fill_r == 6'd63) begin
        // zeros to the end of an overflow block, length goes in the next one
        lenph_nxt = 1'b1;
      end
    end
    if (state_r == ST_OUT && out_tready && oidx_r == 3'd7) begin
      mark_nxt  = 1'b0;
      lenph_nxt = 1'b0;
      fin_nxt   = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    chain_nxt = chain_r;
    rnd_nxt   = rnd_r;
    pad_nxt   = pad_r;
    oidx_nxt  = oidx_r;
    shift_en  = 1'b0;
    shift_val = pad_byte;
    rnd_ctl   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            shift_en  = 1'b1;
            shift_val = in_tdata;
            len_nxt   = len_r + 1'b1;
          end
          if (in_tlast) begin
            pad_nxt   = 1'b1;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_en = 1'b1;
      end
      ST_ROUND: begin
        rnd_ctl.step = 1'b1;
        rnd_nxt      = rnd_r + 1'b1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars[i];
        end
        if (fin_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          oidx_nxt = oidx_r + 1'b1;
          if (oidx_r == 3'd7) begin
            chain_nxt = HashInit;
            len_nxt   = '0;
            fill_nxt  = '0;
            pad_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // one byte into the block; a full block starts the compression
    if (shift_en) begin
      fill_nxt = fill_r + 1'b1;
      if (fill_r == 6'd63) begin
        rnd_ctl.init = 1'b1;
        rnd_nxt      = '0;
        state_nxt    = ST_ROUND;
      end
    end
  end

  always_comb begin
    buf_ctl          = '0;
    buf_ctl.load     = shift_en;
    buf_ctl.expand   = (state_r == ST_ROUND);
    buf_ctl.byte_val = shift_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      chain_r <= HashInit;
      rnd_r   <= '0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      lenph_r <= 1'b0;
      fin_r   <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      chain_r <= chain_nxt;
      rnd_r   <= rnd_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      lenph_r <= lenph_nxt;
      fin_r   <= fin_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // handshake and digest words straight from the chain registers
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = chain_r[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

endmodule

`default_nettype wire

// ===== hdl/shs_port_checker.sv =====
// port-level checks for the stream hasher, bound to the top level
// depends on sha256_stream_hasher ports only
`default_nettype none

module shs_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // input is never taken while a digest is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  // the last digest word is word seven
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tuser == 3'd7))
    else $error("last flag on wrong word index");

  // words follow one another without gaps in index
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tuser == 3'($past(out_tuser) + 3'd1)))
    else $error("digest word index out of sequence");

  // digest ends after the last word transfer
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("digest words after the last one");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher shs_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== bench/sha256_stream_hasher_tb.sv =====
// self-checking bench for sha256_stream_hasher: byte stream in, eight digest words out
// keeps its own sha-256 model of the block; needs only the rtl of the hasher
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

  // sha-256 round constants, k0 in the top word
  localparam logic [64*32-1:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial chaining value, h0 in the top word
  localparam logic [8*32-1:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte    = 8'h80;
  localparam int         PhaseItems = 65;    // counted input transfers per phase
  localparam int         StallLimit = 4000;  // cycles with no transfer at all
  localparam int         TailCycles = 200;   // quiet time after the last digest
  localparam int         MaxReports = 40;

  // one input transfer as queued for the driver
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_msg;
    logic       wait_drain;  // hold back until every digest word is out
  } msg_item_t;

  // one digest word as expected on the output
  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  pos;
    logic        is_last;
  } digest_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] msg_byte
  logic        in_tuser   = 1'b0;    // [0] has_byte
  logic        in_tlast   = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [31:0] digest_word
  logic [2:0]  out_tuser;            // [2:0] word_index
  logic        out_tlast;            // last_word

  sha256_stream_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // hash model: chaining words, block buffer, fill level and byte count
  // ---------------------------------------------------------------------------
  logic [31:0]  chain [8];
  logic [7:0]   blk_bytes [64];
  int           blk_fill;
  logic [60:0]  msg_len;     // wraps modulo 2^61 like the hardware counter

  msg_item_t    pending_items [$];
  digest_word_t expected_digest [$];

  int unsigned  send_gap_pct   = 0;
  int unsigned  recv_stall_pct = 0;
  int           error_count    = 0;
  int           items_in_phase = 0;
  int           items_accepted = 0;
  int           messages_sent  = 0;
  int           words_checked  = 0;
  int           idle_cycles    = 0;
  msg_item_t    held_item;
  digest_word_t want_word;

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 8; i++) chain[i] = InitHash[(7 - i) * 32 +: 32];
    blk_fill = 0;
    msg_len  = '0;
  endfunction

  // 64 rounds over blk_bytes, folded into the chaining words
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
    int t;
    for (t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (t = 16; t < 64; t++) begin
      s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (t = 0; t < 64; t++) begin
      t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
             + ((e & f) ^ (~e & g)) + RoundConst[(63 - t) * 32 +: 32] + w[t];
      t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  // absorb one accepted transfer; an end marker pads, compresses and
  // queues the eight digest words it should produce
  function automatic void hash_item(input msg_item_t it);
    logic [63:0] bit_len;
    int pos;
    int i;
    if (it.has_byte) begin
      blk_bytes[blk_fill] = it.msg_byte;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (!it.end_msg) return;
    pos = blk_fill;
    blk_bytes[pos] = PadByte;
    pos++;
    // no room left for the length: pad out this block and open another
    if (pos > 56) begin
      for (i = pos; i < 64; i++) blk_bytes[i] = 8'h00;
      compress_block();
      pos = 0;
    end
    for (i = pos; i < 56; i++) blk_bytes[i] = 8'h00;
    bit_len = {msg_len, 3'b000};
    for (i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8 * i -: 8];
    compress_block();
    for (i = 0; i < 8; i++)
      expected_digest.push_back('{digest: chain[i], pos: i[2:0], is_last: (i == 7)});
    restart_hash();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxReports)
      $display("[%0t] mismatch %0d: %s got %h want %h", $time, error_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] b, input logic has_b, input logic eom,
                           input logic drain);
    pending_items.push_back('{msg_byte: b, has_byte: has_b, end_msg: eom, wait_drain: drain});
    // idle transfers do nothing, so they are not counted
    if (has_b || eom) items_in_phase++;
  endtask

  // mostly short messages, now and then one that ends near a block boundary
  function automatic int pick_length();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(40);
  endfunction

  // one well-formed message with random bytes and scattered idle transfers;
  // it ends either on its last byte or with a bare end marker
  task automatic queue_message(input int len, input logic drain);
    logic bare_end;
    int i;
    bare_end = (len == 0) || ($urandom_range(2) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) push_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
      push_item(8'($urandom_range(255)), 1'b1, !bare_end && (i == len - 1),
                drain && (i == 0));
    end
    if (bare_end) push_item(8'($urandom_range(255)), 1'b0, 1'b1, drain && (len == 0));
    messages_sent++;
  endtask

  task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                           input int first_len);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    queue_message(first_len, 1'b0);
    while (items_in_phase < PhaseItems)
      queue_message(pick_length(), $urandom_range(9) == 0);
    // sender stays quiet until the block has returned every digest word
    while (pending_items.size() != 0 || in_tvalid || expected_digest.size() != 0)
      @(posedge clk);
    items_in_phase = 0;
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued items, feeds the model on each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        hash_item(held_item);
        items_accepted++;
      end
      if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct &&
          (!pending_items[0].wait_drain || expected_digest.size() == 0)) begin
        held_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= held_item.msg_byte;
        in_tuser  <= held_item.has_byte;
        in_tlast  <= held_item.end_msg;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random backpressure, every digest transfer checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_digest.size() == 0) begin
          report_mismatch("digest word with none expected", out_tdata, 32'h0);
        end else begin
          want_word = expected_digest.pop_front();
          words_checked++;
          if (out_tdata !== want_word.digest)
            report_mismatch("digest word", out_tdata, want_word.digest);
          if (out_tuser !== want_word.pos)
            report_mismatch("word index", {29'h0, out_tuser}, {29'h0, want_word.pos});
          if (out_tlast !== want_word.is_last)
            report_mismatch("last flag", {31'h0, out_tlast}, {31'h0, want_word.is_last});
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: a hung handshake on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    restart_hash();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 19;
    recv_stall_pct = 76;
    // idle transfer, then the empty message by a bare end marker
    push_item(8'h5a, 1'b0, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    // single zero byte, only once the empty digest is fully out
    push_item(8'h00, 1'b1, 1'b1, 1'b1);
    // "abc", ending on its last byte
    push_item(8'h61, 1'b1, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0);
    // bytes with an idle transfer in between, closed by a bare end marker
    push_item(8'hff, 1'b1, 1'b0, 1'b0);
    push_item(8'ha5, 1'b0, 1'b0, 1'b0);
    push_item(8'h80, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    // back-to-back empty message; the ignored byte field is all ones
    push_item(8'hff, 1'b0, 1'b1, 1'b0);
    // extreme byte values, the last one also ending the message
    push_item(8'h00, 1'b1, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0, 1'b0);
    push_item(8'h55, 1'b1, 1'b0, 1'b0);
    push_item(8'haa, 1'b1, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b1, 1'b1);
    messages_sent += 6;

    // length word no longer fits: padding spills into a second block
    run_phase(19, 76, 56);
    // padding just fits behind the data
    run_phase(76, 19, 55);
    // exactly one full block of data, then the end of message
    run_phase(0, 0, 64);

    repeat (TailCycles) @(posedge clk);
    if (expected_digest.size() != 0)
      report_mismatch("digest words never sent", expected_digest.size(), 32'h0);

    $display("covered %0d messages (empty, block-boundary and idle-laden ones) in %0d transfers",
             messages_sent, items_accepted);
    $display("checked %0d digest words under three sender/receiver stall mixes",
             words_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sha256_stream_hasher.f =====
hdl/shs_pkg.sv
hdl/shs_sched.sv
hdl/shs_round.sv
hdl/sha256_stream_hasher.sv
hdl/shs_port_checker.sv
bench/sha256_stream_hasher_tb.sv
